// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- design/kbrsm_pkg.sv -----
// Shared types and codes of the keyboard report slot manager.
// No dependencies; used by kbrsm_slots, the top level and the checker.
package kbrsm_pkg;

	localparam int OUT_SLOTS = 6;
	localparam int WORD_BITS = 64;

	localparam logic [1:0] MODE_AUTO    = 2'd0;
	localparam logic [1:0] MODE_SIX     = 2'd1;
	localparam logic [1:0] MODE_UPGRADE = 2'd2;
	localparam logic [1:0] MODE_NKRO    = 2'd3;

	localparam logic [2:0] KIND_ADD   = 3'd0;
	localparam logic [2:0] KIND_DEL   = 3'd1;
	localparam logic [2:0] KIND_RETRG = 3'd2;
	localparam logic [2:0] KIND_CLEAR = 3'd3;
	localparam logic [2:0] KIND_SEND  = 3'd4;

	localparam logic [1:0] RK_STATUS = 2'd0;
	localparam logic [1:0] RK_BOOT   = 2'd1;
	localparam logic [1:0] RK_WORD   = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_KEY,
		ST_BMW,
		ST_NEXT,
		ST_SRD,
		ST_SCAP,
		ST_SEND_END,
		ST_RRD,
		ST_RLD,
		ST_PRES,
		ST_PCHK,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		SOP_ADD,
		SOP_DEL,
		SOP_CLR
	} slot_op_t;

	typedef struct packed {
		logic     en;
		slot_op_t op;
		logic     six;
		logic [7:0] key;
	} slot_cmd_t;

endpackage

// ----- design/kbrsm_ram.sv -----
// Simple dual-port synchronous RAM: one write port, one read port, registered read data.
// No dependencies.
module kbrsm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- design/kbrsm_slots.sv -----
// Boot report slot table with per-slot wrapping ages: add, delete and clear.
// Depends on kbrsm_pkg.
module kbrsm_slots #(
	parameter int SLOT_COUNT = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  kbrsm_pkg::slot_cmd_t cmd,
	output logic [7:0]           keys [SLOT_COUNT],
	output logic                 overflow,
	output logic                 empty
);
	localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	logic [7:0] keys_q [SLOT_COUNT];
	logic [7:0] ages_q [SLOT_COUNT];
	logic [7:0] keys_d [SLOT_COUNT];
	logic [7:0] ages_d [SLOT_COUNT];

	always_comb begin
		logic [7:0]    k;
		logic [7:0]    best_age;
		logic [IW-1:0] best;
		keys_d   = keys_q;
		ages_d   = ages_q;
		k        = cmd.key;
		best_age = 8'd0;
		best     = '0;
		overflow = 1'b0;
		case (cmd.op)
			kbrsm_pkg::SOP_ADD: begin
				// The key lands in the first empty or matching slot; later empty
				// slots are rewritten with zero and get their ages cleared too.
				for (int i = 0; i < SLOT_COUNT; i++) begin
					if (keys_q[i] == 8'd0 || (k != 8'd0 && keys_q[i] == k)) begin
						keys_d[i] = k;
						ages_d[i] = 8'd0;
						k = 8'd0;
					end else begin
						ages_d[i] = ages_q[i] + 8'd1;
					end
				end
				overflow = cmd.en && (k != 8'd0);
				if (k != 8'd0 && cmd.six) begin
					for (int i = 0; i < SLOT_COUNT; i++) begin
						if (ages_d[i] > best_age) begin
							best_age = ages_d[i];
							best = IW'(i);
						end
					end
					keys_d[best] = k;
					ages_d[best] = 8'd0;
				end
			end
			kbrsm_pkg::SOP_DEL: begin
				for (int i = 0; i < SLOT_COUNT; i++) begin
					if (keys_q[i] == cmd.key) begin
						keys_d[i] = 8'd0;
					end
					ages_d[i] = ages_q[i] - 8'd1;
				end
			end
			kbrsm_pkg::SOP_CLR: begin
				for (int i = 0; i < SLOT_COUNT; i++) begin
					keys_d[i] = 8'd0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				keys_q[i] <= 8'd0;
				ages_q[i] <= 8'd0;
			end
		end else if (cmd.en) begin
			keys_q <= keys_d;
			ages_q <= ages_d;
		end
	end

	always_comb begin
		empty = 1'b1;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			keys[i] = keys_q[i];
			if (keys_q[i] != 8'd0) begin
				empty = 1'b0;
			end
		end
	end
endmodule

// ----- design/keyboard_report_slot_manager.sv -----
// Top level of the keyboard report slot manager: sequencer, registers, result port.
// Depends on kbrsm_pkg, kbrsm_ram and kbrsm_slots.
//
// Channel   | Handshake                      | Payload
// ----------+--------------------------------+-----------------------------------------
// command   | start, busy                    | kind, keycode, boot_ready, nkro_ready
// result    | done (one result per cycle)    | key_present .. bitmap_word, last
// config    | psel, penable, pwrite, pready  | paddr, pwdata, prdata
//
// Add or delete: slot update, bitmap read-modify-write and presence check, then
// the results. A dirty send also reads and captures each bitmap word, and replays
// each stored key through the slot update and, when it writes the bitmap, the
// read-modify-write, over the read and write ports of the bitmap memory. Reset
// clears the slot table and the bitmap valid flags at once; no clearing pass.
// The block is busy from a command transfer until its last result; results cannot stall.
module keyboard_report_slot_manager #(
	parameter int SLOT_COUNT   = 6,
	parameter int REPLAY_DEPTH = 6,
	parameter int BITMAP_BITS  = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  kind,
	input  logic [7:0]  keycode,
	input  logic        boot_ready,
	input  logic        nkro_ready,
	output logic        done,
	output logic        key_present,
	output logic [1:0]  mode_now,
	output logic        pending,
	output logic [1:0]  report_kind,
	output logic [7:0]  slot_key0,
	output logic [7:0]  slot_key1,
	output logic [7:0]  slot_key2,
	output logic [7:0]  slot_key3,
	output logic [7:0]  slot_key4,
	output logic [7:0]  slot_key5,
	output logic [63:0] bitmap_word,
	output logic        last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int NW       = (BITMAP_BITS + 63) / 64;
	localparam int BM_AW    = (NW > 1) ? $clog2(NW) : 1;
	localparam int BM_DEPTH = 1 << BM_AW;
	localparam int RAW      = (REPLAY_DEPTH > 1) ? $clog2(REPLAY_DEPTH) : 1;
	localparam int RCW      = $clog2(REPLAY_DEPTH + 1);
	localparam int OS       = kbrsm_pkg::OUT_SLOTS;

	kbrsm_pkg::state_t state_q, state_d;

	logic [1:0]       start_mode_q, mode_q;
	logic             dirty_q;
	logic [2:0]       kind_q;
	logic [7:0]       kc_q, op_key_q;
	logic             op_del_q, bm_on_q;
	logic             fail_q, status_q, emit_nk_q, emit_boot_q;
	logic             in_replay_q, present_q;
	logic [RCW-1:0]   rcount_q, ridx_q;
	logic [BM_AW-1:0] word_q;
	logic [2:0]       eidx_q;
	logic [63:0]      wbuf_q [NW];
	logic [7:0]       boot_buf_q [OS];
	logic             bm_valid_q [BM_DEPTH];
	logic             bm_rvalid_q;

	logic             done_q, present_out_q, pending_q, last_q;
	logic [1:0]       mode_out_q, rk_q;
	logic [7:0]       slot_out_q [OS];
	logic [63:0]      word_out_q;

	logic                 accept, cfg_wr;
	kbrsm_pkg::slot_cmd_t slot_cmd;
	logic [7:0]           keys [SLOT_COUNT];
	logic [7:0]           cur_slots [OS];
	logic                 slot_ovf, slot_empty, slot_hit;
	logic                 bm_we;
	logic [BM_AW-1:0]     bm_waddr, bm_raddr;
	logic [63:0]          bm_wdata, bm_rdata, bm_rd;
	logic                 rp_we;
	logic [RAW-1:0]       rp_waddr, rp_raddr;
	logic [7:0]           rp_rdata;
	logic                 op_in_bm, kc_in_bm, bm_go, rp_more;
	logic                 do_nkro, do_boot, now_nk, now_boot, now_fail;
	logic [RCW-1:0]       ridx_inc;
	logic [2:0]           n_last;
	logic                 is_word;

	assign accept = start && (state_q == kbrsm_pkg::ST_IDLE);
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
	assign busy   = (state_q != kbrsm_pkg::ST_IDLE);
	assign pready = 1'b1;
	assign prdata = {30'd0, start_mode_q};

	kbrsm_slots #(.SLOT_COUNT(SLOT_COUNT)) u_slots (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (slot_cmd),
		.keys     (keys),
		.overflow (slot_ovf),
		.empty    (slot_empty)
	);

	kbrsm_ram #(.WIDTH(64), .DEPTH(BM_DEPTH)) u_bitmap (
		.clk   (clk),
		.we    (bm_we),
		.waddr (bm_waddr),
		.wdata (bm_wdata),
		.raddr (bm_raddr),
		.rdata (bm_rdata)
	);

	kbrsm_ram #(.WIDTH(8), .DEPTH(REPLAY_DEPTH)) u_replay (
		.clk   (clk),
		.we    (rp_we),
		.waddr (rp_waddr),
		.wdata (kc_q),
		.raddr (rp_raddr),
		.rdata (rp_rdata)
	);

	// A bitmap word never written since reset or the last clear reads as zero.
	assign bm_rd = bm_rvalid_q ? bm_rdata : 64'd0;

	always_comb begin
		slot_hit = 1'b0;
		for (int j = 0; j < OS; j++) begin
			cur_slots[j] = (j < SLOT_COUNT) ? keys[j] : 8'd0;
		end
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (keys[i] == kc_q) begin
				slot_hit = 1'b1;
			end
		end
	end

	assign op_in_bm = ({1'b0, op_key_q} < 9'(BITMAP_BITS));
	assign kc_in_bm = ({1'b0, kc_q} < 9'(BITMAP_BITS));
	assign bm_go    = op_in_bm && (op_del_q || (mode_q == kbrsm_pkg::MODE_UPGRADE) ||
		(mode_q == kbrsm_pkg::MODE_NKRO) || ((mode_q == kbrsm_pkg::MODE_AUTO) && slot_ovf));
	assign ridx_inc = ridx_q + RCW'(1);
	assign rp_more  = (ridx_inc < rcount_q);

	assign do_nkro  = mode_q[1];
	assign do_boot  = (mode_q != kbrsm_pkg::MODE_NKRO);
	assign now_nk   = do_nkro && nkro_ready;
	assign now_boot = do_boot && boot_ready;
	assign now_fail = (do_nkro && !nkro_ready) || (do_boot && !boot_ready);

	assign n_last  = status_q ? 3'd0 :
		3'((emit_nk_q ? NW : 0) + (emit_boot_q ? 1 : 0) - 1);
	assign is_word = emit_nk_q && !status_q && (eidx_q < 3'(NW));

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			kbrsm_pkg::ST_IDLE: begin
				if (start) begin
					case (kind)
						kbrsm_pkg::KIND_ADD, kbrsm_pkg::KIND_DEL, kbrsm_pkg::KIND_RETRG: begin
							state_d = (keycode != 8'd0) ? kbrsm_pkg::ST_KEY : kbrsm_pkg::ST_PRES;
						end
						kbrsm_pkg::KIND_SEND: begin
							if (!dirty_q) begin
								state_d = kbrsm_pkg::ST_PRES;
							end else if (now_nk) begin
								state_d = kbrsm_pkg::ST_SRD;
							end else begin
								state_d = kbrsm_pkg::ST_SEND_END;
							end
						end
						default: state_d = kbrsm_pkg::ST_PRES;
					endcase
				end
			end
			kbrsm_pkg::ST_KEY:  state_d = bm_go ? kbrsm_pkg::ST_BMW : kbrsm_pkg::ST_NEXT;
			kbrsm_pkg::ST_BMW:  state_d = kbrsm_pkg::ST_NEXT;
			kbrsm_pkg::ST_NEXT: begin
				state_d = (in_replay_q && rp_more) ? kbrsm_pkg::ST_RRD : kbrsm_pkg::ST_PRES;
			end
			kbrsm_pkg::ST_SRD:  state_d = kbrsm_pkg::ST_SCAP;
			kbrsm_pkg::ST_SCAP: begin
				state_d = (word_q == BM_AW'(NW - 1)) ? kbrsm_pkg::ST_SEND_END : kbrsm_pkg::ST_SRD;
			end
			kbrsm_pkg::ST_SEND_END: begin
				state_d = (!fail_q && rcount_q != '0) ? kbrsm_pkg::ST_RRD : kbrsm_pkg::ST_PRES;
			end
			kbrsm_pkg::ST_RRD:  state_d = kbrsm_pkg::ST_RLD;
			kbrsm_pkg::ST_RLD:  state_d = kbrsm_pkg::ST_KEY;
			kbrsm_pkg::ST_PRES: state_d = kbrsm_pkg::ST_PCHK;
			kbrsm_pkg::ST_PCHK: state_d = kbrsm_pkg::ST_EMIT;
			kbrsm_pkg::ST_EMIT: begin
				state_d = (eidx_q == n_last) ? kbrsm_pkg::ST_IDLE : kbrsm_pkg::ST_EMIT;
			end
			default: state_d = kbrsm_pkg::ST_IDLE;
		endcase
	end

	// Memory and slot table controls.
	always_comb begin
		slot_cmd     = '0;
		slot_cmd.key = op_key_q;
		slot_cmd.op  = op_del_q ? kbrsm_pkg::SOP_DEL : kbrsm_pkg::SOP_ADD;
		slot_cmd.six = (mode_q == kbrsm_pkg::MODE_SIX);
		bm_we        = 1'b0;
		bm_waddr     = op_key_q[6 +: BM_AW];
		bm_raddr     = op_key_q[6 +: BM_AW];
		bm_wdata     = bm_rd;
		rp_we        = 1'b0;
		rp_waddr     = rcount_q[RAW-1:0];
		rp_raddr     = ridx_q[RAW-1:0];
		case (state_q)
			kbrsm_pkg::ST_IDLE: begin
				if (accept && kind == kbrsm_pkg::KIND_CLEAR) begin
					slot_cmd.en = 1'b1;
					slot_cmd.op = kbrsm_pkg::SOP_CLR;
				end
			end
			kbrsm_pkg::ST_KEY: begin
				slot_cmd.en = op_del_q ? (mode_q != kbrsm_pkg::MODE_NKRO) :
					(mode_q == kbrsm_pkg::MODE_AUTO || mode_q == kbrsm_pkg::MODE_SIX);
			end
			kbrsm_pkg::ST_BMW: begin
				bm_we = 1'b1;
				if (bm_on_q) begin
					bm_wdata = bm_rd | (64'd1 << op_key_q[5:0]);
				end else begin
					bm_wdata = bm_rd & ~(64'd1 << op_key_q[5:0]);
				end
			end
			kbrsm_pkg::ST_NEXT: begin
				rp_we = !in_replay_q && (kind_q == kbrsm_pkg::KIND_RETRG) &&
					(rcount_q < RCW'(REPLAY_DEPTH));
			end
			kbrsm_pkg::ST_SRD:  bm_raddr = word_q;
			kbrsm_pkg::ST_PRES: bm_raddr = kc_q[6 +: BM_AW];
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= kbrsm_pkg::ST_IDLE;
			start_mode_q <= kbrsm_pkg::MODE_AUTO;
			mode_q       <= kbrsm_pkg::MODE_AUTO;
			dirty_q      <= 1'b1;
			rcount_q     <= '0;
			ridx_q       <= '0;
			in_replay_q  <= 1'b0;
			done_q       <= 1'b0;
			bm_rvalid_q  <= 1'b0;
			for (int i = 0; i < BM_DEPTH; i++) begin
				bm_valid_q[i] <= 1'b0;
			end
		end else begin
			state_q     <= state_d;
			done_q      <= (state_q == kbrsm_pkg::ST_EMIT);
			bm_rvalid_q <= bm_valid_q[bm_raddr];
			if (bm_we) begin
				bm_valid_q[bm_waddr] <= 1'b1;
			end
			if (cfg_wr) begin
				start_mode_q <= pwdata[1:0];
				mode_q       <= pwdata[1:0];
			end
			case (state_q)
				kbrsm_pkg::ST_IDLE: begin
					in_replay_q <= 1'b0;
					if (accept && kind == kbrsm_pkg::KIND_CLEAR) begin
						dirty_q <= 1'b1;
						for (int i = 0; i < BM_DEPTH; i++) begin
							bm_valid_q[i] <= 1'b0;
						end
					end
				end
				kbrsm_pkg::ST_KEY: begin
					dirty_q <= 1'b1;
					if (!op_del_q && mode_q == kbrsm_pkg::MODE_AUTO && slot_ovf) begin
						mode_q <= kbrsm_pkg::MODE_UPGRADE;
					end
				end
				kbrsm_pkg::ST_NEXT: begin
					if (in_replay_q) begin
						if (rp_more) begin
							ridx_q <= ridx_inc;
						end else begin
							rcount_q    <= '0;
							in_replay_q <= 1'b0;
						end
					end else if (rp_we) begin
						rcount_q <= rcount_q + RCW'(1);
					end
				end
				kbrsm_pkg::ST_SEND_END: begin
					if (mode_q == kbrsm_pkg::MODE_UPGRADE && slot_empty) begin
						mode_q <= kbrsm_pkg::MODE_NKRO;
					end
					if (!fail_q) begin
						dirty_q <= 1'b0;
						if (rcount_q != '0) begin
							in_replay_q <= 1'b1;
							ridx_q      <= '0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Payload registers of the command in flight and of the result port.
	always_ff @(posedge clk) begin
		case (state_q)
			kbrsm_pkg::ST_IDLE: begin
				if (accept) begin
					kind_q   <= kind;
					kc_q     <= keycode;
					op_key_q <= keycode;
					op_del_q <= (kind != kbrsm_pkg::KIND_ADD);
					word_q   <= '0;
					eidx_q   <= 3'd0;
					boot_buf_q <= cur_slots;
					if (kind == kbrsm_pkg::KIND_SEND && dirty_q) begin
						emit_nk_q   <= now_nk;
						emit_boot_q <= now_boot;
						fail_q      <= now_fail;
						status_q    <= !(now_nk || now_boot);
					end else begin
						emit_nk_q   <= 1'b0;
						emit_boot_q <= 1'b0;
						fail_q      <= 1'b0;
						status_q    <= 1'b1;
					end
				end
			end
			kbrsm_pkg::ST_KEY:  bm_on_q <= !op_del_q;
			kbrsm_pkg::ST_SCAP: begin
				wbuf_q[word_q] <= bm_rd;
				word_q <= word_q + BM_AW'(1);
			end
			kbrsm_pkg::ST_RLD: begin
				op_key_q <= rp_rdata;
				op_del_q <= 1'b0;
			end
			kbrsm_pkg::ST_PRES: present_q <= slot_hit;
			kbrsm_pkg::ST_PCHK: begin
				if (mode_q == kbrsm_pkg::MODE_NKRO) begin
					present_q <= kc_in_bm && bm_rd[kc_q[5:0]];
				end
			end
			kbrsm_pkg::ST_EMIT: begin
				eidx_q        <= eidx_q + 3'd1;
				present_out_q <= present_q;
				mode_out_q    <= mode_q;
				pending_q     <= fail_q;
				last_q        <= (eidx_q == n_last);
				if (status_q) begin
					rk_q       <= kbrsm_pkg::RK_STATUS;
					slot_out_q <= cur_slots;
					word_out_q <= 64'd0;
				end else if (is_word) begin
					rk_q       <= kbrsm_pkg::RK_WORD;
					word_out_q <= wbuf_q[eidx_q[BM_AW-1:0]];
					for (int j = 0; j < OS; j++) begin
						slot_out_q[j] <= 8'd0;
					end
				end else begin
					rk_q       <= kbrsm_pkg::RK_BOOT;
					slot_out_q <= boot_buf_q;
					word_out_q <= 64'd0;
				end
			end
			default: begin
			end
		endcase
	end

	assign done        = done_q;
	assign key_present = present_out_q;
	assign mode_now    = mode_out_q;
	assign pending     = pending_q;
	assign report_kind = rk_q;
	assign slot_key0   = slot_out_q[0];
	assign slot_key1   = slot_out_q[1];
	assign slot_key2   = slot_out_q[2];
	assign slot_key3   = slot_out_q[3];
	assign slot_key4   = slot_out_q[4];
	assign slot_key5   = slot_out_q[5];
	assign bitmap_word = word_out_q;
	assign last        = last_q;
endmodule

// ----- design/kbrsm_checker.sv -----
// Port-level checker of the keyboard report slot manager, bound to the top level.
// Depends on assert_macros.svh and kbrsm_pkg.
`include "assert_macros.svh"

module kbrsm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic        last,
	input logic [1:0]  report_kind,
	input logic [63:0] bitmap_word
);
	// A command transfer always leads to work in flight.
	`ASSERT_NEXT(a_start_busy, start && !busy, busy)
	// The block goes idle exactly as its final result shows.
	`ASSERT_IMPL(a_idle_last, $fell(busy), done && last)
	// Results of one command come in an unbroken burst.
	`ASSERT_NEXT(a_burst, done && !last, done)
	// Only an nkro word result carries bitmap data.
	`ASSERT_IMPL(a_word_zero, done && report_kind != kbrsm_pkg::RK_WORD, bitmap_word == 64'd0)
endmodule

bind keyboard_report_slot_manager kbrsm_checker u_kbrsm_checker (.*);
